// ----- hdl/bfiq_pkg.sv -----
// Shared constants and types for the Bloom filter insert/query engine.
// No dependencies; imported by every module under hdl/.
package bfiq_pkg;

	localparam int unsigned MAX_HASHES  = 16;
	localparam int unsigned LANE_W      = $clog2(MAX_HASHES);
	localparam int unsigned CNT_W       = $clog2(MAX_HASHES + 1);

	localparam int unsigned HASH_W      = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned HASH_SHIFT  = 15;

	localparam int unsigned HC_W        = 5;
	localparam logic [HC_W-1:0] HASH_COUNT_RESET = 5'd10;

	// Filter store: power-of-two size, organized as rows of WORD_W bits.
	localparam int unsigned FILTER_BITS = 65536;
	localparam int unsigned POS_W       = $clog2(FILTER_BITS);
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BIT_W       = $clog2(WORD_W);
	localparam int unsigned ROWS        = FILTER_BITS / WORD_W;
	localparam int unsigned ROW_W       = $clog2(ROWS);

	typedef logic [LANE_W-1:0] lane_idx_t;
	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [WORD_W-1:0] word_t;

	localparam hash_t HASH_MUL = 32'h5bd1e995;

	typedef struct packed {
		logic              valid;
		lane_idx_t         lane;
		hash_t             hash;
		logic [BYTE_W-1:0] data;
	} fold_req_t;

	typedef struct packed {
		logic      valid;
		lane_idx_t lane;
		hash_t     hash;
	} fold_rsp_t;

	typedef struct packed {
		logic  rd_en;
		logic  we;
		row_t  row;
		word_t wdata;
	} store_req_t;

endpackage

// ----- hdl/bfiq_fold_unit.sv -----
// Shared hash fold unit: xor byte and multiply, register, then xor-shift;
// the response follows the request in the next cycle. Depends on bfiq_pkg.
module bfiq_fold_unit import bfiq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fold_req_t req,
	output fold_rsp_t rsp
);

	hash_t                mix;
	hash_t                prod;
	logic                 valid_s1;
	lane_idx_t            lane_s1;
	hash_t                prod_s1;

	// keep only the low word of the product: multiply mod 2^32
	assign mix  = req.hash ^ {{(HASH_W-BYTE_W){1'b0}}, req.data};
	assign prod = mix * HASH_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			lane_s1 <= req.lane;
			prod_s1 <= prod;
		end
	end

	assign rsp.valid = valid_s1;
	assign rsp.lane  = lane_s1;
	assign rsp.hash  = prod_s1 ^ (prod_s1 >> HASH_SHIFT);

endmodule

// ----- hdl/bfiq_bit_store.sv -----
// Filter bit store: word-wide memory with registered read and a clearing sweep
// after reset. Depends on bfiq_pkg.
module bfiq_bit_store import bfiq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output word_t      rdata,
	output logic       busy
);

	word_t mem [ROWS];
	logic  clr_busy_q;
	row_t  clr_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + row_t'(1);
			if (clr_row_q == row_t'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// clear sweep owns the write port until it finishes
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_row_q] <= '0;
		end else if (req.we) begin
			mem[req.row] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[req.row];
		end
	end

	assign busy = clr_busy_q;

endmodule

// ----- hdl/bloom_filter_insert_query.sv -----
// Bloom filter insert/query engine, top level.
// Depends on bfiq_pkg, bfiq_fold_unit and bfiq_bit_store.
//
// Keys arrive one byte per input word (mode, key_byte, last_byte). Sixteen
// running 32-bit hashes, lane i seeded with i, each fold every byte as
// h ^= byte; h *= 0x5bd1e995; h ^= h >> 15. One shared fold unit (a single
// 32x32 multiplier, registered) serves all lanes in turn, with in_stall held
// high while they fold. On a byte marked last, the low 16 bits of the first
// min(hash_count, 16) lanes each pick one bit of a 65536-bit store; each pick
// is a read then a check-or-set of one 32-bit store row. Only the mode of the
// last byte counts. A query returns is_member = 1 only if every picked bit
// was set (and 1 when hash_count is 0); an insert sets the bits and returns
// is_member = 0 with was_insert = 1. Lanes reseed after each key. After reset
// the store is cleared one row per cycle, all 2048 rows, with in_stall held
// high. hash_count (reset 10) is written through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block does not enforce this. The
// result register lets the next byte start while a result waits.
module bloom_filter_insert_query import bfiq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [BYTE_W-1:0] key_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_member,
	output logic              was_insert,
	input  logic              cfg_we,
	input  logic [HC_W-1:0]   cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FOLD = 5'b00010,
		ST_PRD  = 5'b00100,
		ST_PCHK = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t            state_q;
	logic [HC_W-1:0]   hash_count_q;
	logic [CNT_W-1:0]  probe_total;
	logic [CNT_W-1:0]  issue_cnt_q;
	logic [CNT_W-1:0]  probe_cnt_q;
	logic [BYTE_W-1:0] byte_q;
	logic              mode_q;
	logic              last_q;
	logic              member_q;
	logic              out_valid_q;
	logic              is_member_q;
	logic              was_insert_q;
	hash_t             lane_q [MAX_HASHES];
	lane_idx_t         rd_idx;
	hash_t             rd_hash;
	logic [BIT_W-1:0]  bit_sel;
	word_t             bit_mask;
	logic              bit_hit;
	logic              accept_in;
	logic              fold_done;
	logic              probe_last;
	logic              load_out;
	logic              reseed;
	fold_req_t         fold_req;
	fold_rsp_t         fold_rsp;
	store_req_t        store_req;
	word_t             store_rdata;
	logic              store_busy;

	// ---- configuration -------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q <= HASH_COUNT_RESET;
		end else if (cfg_we) begin
			hash_count_q <= cfg_wdata;
		end
	end

	// saturate the lane count at the number of lanes built
	assign probe_total = (hash_count_q > HC_W'(MAX_HASHES)) ?
		CNT_W'(MAX_HASHES) : CNT_W'(hash_count_q);

	// ---- handshakes ----------------------------------------------------
	assign in_stall   = (state_q != ST_IDLE) || store_busy;
	assign accept_in  = in_valid && !in_stall;
	assign fold_done  = (state_q == ST_FOLD) && (issue_cnt_q == CNT_W'(MAX_HASHES));
	assign probe_last = (probe_cnt_q + CNT_W'(1)) == probe_total;
	assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// reseed as soon as the last probe is done (or at once with no probes)
	assign reseed = (fold_done && last_q && (probe_total == '0)) ||
		((state_q == ST_PCHK) && probe_last);

	// ---- lane register file: one read index, shared by fold and probe ----
	assign rd_idx  = (state_q == ST_FOLD) ? issue_cnt_q[LANE_W-1:0]
		: probe_cnt_q[LANE_W-1:0];
	assign rd_hash = lane_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_HASHES; i++) begin
				lane_q[i] <= HASH_W'(i);
			end
		end else if (reseed) begin
			for (int i = 0; i < MAX_HASHES; i++) begin
				lane_q[i] <= HASH_W'(i);
			end
		end else if (fold_rsp.valid) begin
			lane_q[fold_rsp.lane] <= fold_rsp.hash;
		end
	end

	// ---- shared fold unit: issue one lane per cycle ---------------------
	assign fold_req.valid = (state_q == ST_FOLD) && (issue_cnt_q != CNT_W'(MAX_HASHES));
	assign fold_req.lane  = issue_cnt_q[LANE_W-1:0];
	assign fold_req.hash  = rd_hash;
	assign fold_req.data  = byte_q;

	bfiq_fold_unit u_fold (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fold_req),
		.rsp    (fold_rsp)
	);

	// ---- filter store: read a row, then check or set one bit -------------
	// position = hash mod FILTER_BITS; upper bits pick the row, lower the bit
	assign bit_sel  = rd_hash[BIT_W-1:0];
	assign bit_mask = word_t'(1) << bit_sel;
	assign bit_hit  = |(store_rdata & bit_mask);

	assign store_req.rd_en = (state_q == ST_PRD);
	assign store_req.we    = (state_q == ST_PCHK) && mode_q;
	assign store_req.row   = rd_hash[POS_W-1:BIT_W];
	assign store_req.wdata = store_rdata | bit_mask;

	bfiq_bit_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rdata  (store_rdata),
		.busy   (store_busy)
	);

	// ---- sequencer -------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_cnt_q <= '0;
			probe_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						issue_cnt_q <= '0;
						state_q     <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (fold_done) begin
						probe_cnt_q <= '0;
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else if (probe_total == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_PRD;
						end
					end else begin
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
					end
				end
				ST_PRD: begin
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					probe_cnt_q <= probe_cnt_q + CNT_W'(1);
					state_q     <= probe_last ? ST_EMIT : ST_PRD;
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the accepted word for the whole fold
	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_q <= key_byte;
			mode_q <= mode;
			last_q <= last_byte;
		end
	end

	// membership flag: start true, drop on any clear bit during a query
	always_ff @(posedge clk) begin
		if (accept_in) begin
			member_q <= 1'b1;
		end else if ((state_q == ST_PCHK) && !mode_q && !bit_hit) begin
			member_q <= 1'b0;
		end
	end

	// ---- result register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			is_member_q  <= member_q && !mode_q;
			was_insert_q <= mode_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_member  = is_member_q;
	assign was_insert = was_insert_q;

endmodule
